[rtl/wds_pkg.sv]
// Shared types and constants for the windowed duration statistics block.
// No dependencies; used by the top level and the port checker.
package wds_pkg;

   localparam int SAMPLES = 16;
   localparam int SLOT_W  = $clog2(SAMPLES);
   localparam int DUR_W   = 32;
   localparam int SUM_W   = 40;

   // scan counter runs 0..SAMPLES: reads issued below SAMPLES, last data at SAMPLES
   localparam logic [SLOT_W:0]   SCAN_LAST = (SLOT_W + 1)'(SAMPLES);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLES - 1);

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_STOP   = 2'd1,
      OP_FINISH = 2'd2,
      OP_ENABLE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STOP = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

endpackage

[rtl/windowed_duration_statistics.sv]
// Windowed duration statistics: per-slot duration and start-time RAMs, window scan.
// Depends on wds_pkg and wds_ram.
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------------
//   request   start / busy       req_operation, req_timestamp_ms, req_enable_request
//   response  rsp_strobe         rsp_interval_ms, rsp_window_min, rsp_window_max,
//                                rsp_window_sum, rsp_stats_valid
//
// Start, set-enable and inactive stop: word out on the next cycle.
// Active stop: start-time/duration RAM read, then duration write-back.
// Finish: one duration RAM read per slot during the scan.
// Reset clears per-slot valid bits at once, so no clearing pass is needed.
// The receiver cannot stall; each response word is shown for one cycle.
module windowed_duration_statistics (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [31:0]         req_timestamp_ms,
   input  logic                req_enable_request,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_interval_ms,
   output logic signed [31:0]  rsp_window_min,
   output logic signed [31:0]  rsp_window_max,
   output logic signed [39:0]  rsp_window_sum,
   output logic                rsp_stats_valid
);

   wds_pkg::state_type state_ff, state_in;

   logic [wds_pkg::SLOT_W-1:0] ptr_ff;
   logic [wds_pkg::SLOT_W:0]   cnt_ff;
   logic                       active_ff;
   logic                       requested_ff;
   logic [wds_pkg::DUR_W-1:0]  ts_ff;
   logic [wds_pkg::SAMPLES-1:0] dur_vld_ff;
   logic [wds_pkg::SAMPLES-1:0] st_vld_ff;
   logic                       dur_rv_ff;
   logic                       st_rv_ff;

   logic signed [wds_pkg::DUR_W-1:0] min_ff, max_ff;
   logic signed [wds_pkg::SUM_W-1:0] sum_ff;

   logic                             rsp_strobe_ff;
   logic signed [wds_pkg::DUR_W-1:0] rsp_interval_ff, rsp_min_ff, rsp_max_ff;
   logic signed [wds_pkg::SUM_W-1:0] rsp_sum_ff;
   logic                             rsp_stats_ff;

   logic                       accept;
   wds_pkg::op_type            op;
   logic [wds_pkg::SLOT_W-1:0] dur_raddr;
   logic [wds_pkg::DUR_W-1:0]  dur_rdata, st_rdata, dur_q, st_q, dt, dur_new;
   logic                       dur_we, st_we;
   logic                       scan_first;
   logic signed [wds_pkg::DUR_W-1:0] d_s, min_nx, max_nx;
   logic signed [wds_pkg::SUM_W-1:0] sum_nx;
   logic [wds_pkg::SLOT_W-1:0] ptr_next;

   assign busy   = (state_ff != wds_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign op     = wds_pkg::op_type'(req_operation);

   always_comb begin
      dur_raddr = (state_ff == wds_pkg::ST_SCAN) ? cnt_ff[wds_pkg::SLOT_W-1:0] : ptr_ff;
      // entries never written since reset read as zero
      dur_q     = dur_rv_ff ? dur_rdata : '0;
      st_q      = st_rv_ff ? st_rdata : '0;
      dt        = ts_ff - st_q;
      dur_new   = dur_q + dt;
      dur_we    = (state_ff == wds_pkg::ST_STOP);
      st_we     = accept && (op == wds_pkg::OP_START) && active_ff;
      ptr_next  = (ptr_ff == wds_pkg::SLOT_LAST) ? '0 : ptr_ff + 1'b1;

      scan_first = (cnt_ff == (wds_pkg::SLOT_W + 1)'(1));
      d_s        = $signed(dur_q);
      if (scan_first) begin
         min_nx = d_s;
         max_nx = d_s;
         sum_nx = wds_pkg::SUM_W'(d_s);
      end else begin
         min_nx = (d_s < min_ff) ? d_s : min_ff;
         max_nx = (d_s > max_ff) ? d_s : max_ff;
         sum_nx = sum_ff + wds_pkg::SUM_W'(d_s);
      end

      state_in = state_ff;
      unique case (state_ff)
         wds_pkg::ST_IDLE: begin
            if (accept && op == wds_pkg::OP_STOP && active_ff) begin
               state_in = wds_pkg::ST_STOP;
            end else if (accept && op == wds_pkg::OP_FINISH) begin
               state_in = wds_pkg::ST_SCAN;
            end
         end
         wds_pkg::ST_STOP: state_in = wds_pkg::ST_IDLE;
         wds_pkg::ST_SCAN: begin
            if (cnt_ff == wds_pkg::SCAN_LAST) begin
               state_in = wds_pkg::ST_IDLE;
            end
         end
         default: state_in = wds_pkg::ST_IDLE;
      endcase
   end

   wds_ram #(.WIDTH(wds_pkg::DUR_W), .DEPTH(wds_pkg::SAMPLES)) u_dur_ram (
      .clock   (clock),
      .wr_en   (dur_we),
      .wr_addr (ptr_ff),
      .wr_data (dur_new),
      .rd_addr (dur_raddr),
      .rd_data (dur_rdata)
   );

   wds_ram #(.WIDTH(wds_pkg::DUR_W), .DEPTH(wds_pkg::SAMPLES)) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (ptr_ff),
      .wr_data (req_timestamp_ms),
      .rd_addr (ptr_ff),
      .rd_data (st_rdata)
   );

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      dur_rv_ff <= dur_vld_ff[dur_raddr];
      st_rv_ff  <= st_vld_ff[ptr_ff];
      if (accept) begin
         ts_ff <= req_timestamp_ms;
      end
      if (state_ff == wds_pkg::ST_SCAN && cnt_ff != '0) begin
         min_ff <= min_nx;
         max_ff <= max_nx;
         sum_ff <= sum_nx;
      end
      rsp_interval_ff <= '0;
      rsp_min_ff      <= '0;
      rsp_max_ff      <= '0;
      rsp_sum_ff      <= '0;
      rsp_stats_ff    <= 1'b0;
      if (state_ff == wds_pkg::ST_STOP) begin
         rsp_interval_ff <= $signed(dt);
      end
      if (state_ff == wds_pkg::ST_SCAN && cnt_ff == wds_pkg::SCAN_LAST) begin
         rsp_min_ff   <= min_nx;
         rsp_max_ff   <= max_nx;
         rsp_sum_ff   <= sum_nx;
         rsp_stats_ff <= 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wds_pkg::ST_IDLE;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         active_ff     <= 1'b0;
         requested_ff  <= 1'b0;
         dur_vld_ff    <= '0;
         st_vld_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            wds_pkg::ST_IDLE: begin
               if (accept) begin
                  unique case (op)
                     wds_pkg::OP_START: begin
                        if (active_ff) begin
                           st_vld_ff[ptr_ff] <= 1'b1;
                        end
                        rsp_strobe_ff <= 1'b1;
                     end
                     wds_pkg::OP_STOP: begin
                        // active stop answers after the write-back cycle
                        rsp_strobe_ff <= !active_ff;
                     end
                     wds_pkg::OP_FINISH: begin
                        ptr_ff <= ptr_next;
                        cnt_ff <= '0;
                     end
                     wds_pkg::OP_ENABLE: begin
                        requested_ff  <= req_enable_request;
                        rsp_strobe_ff <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            wds_pkg::ST_STOP: begin
               dur_vld_ff[ptr_ff] <= 1'b1;
               rsp_strobe_ff      <= 1'b1;
            end
            wds_pkg::ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == wds_pkg::SCAN_LAST) begin
                  // new slot starts the frame empty
                  dur_vld_ff[ptr_ff] <= 1'b0;
                  active_ff          <= requested_ff;
                  rsp_strobe_ff      <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_interval_ms = rsp_interval_ff;
   assign rsp_window_min  = rsp_min_ff;
   assign rsp_window_max  = rsp_max_ff;
   assign rsp_window_sum  = rsp_sum_ff;
   assign rsp_stats_valid = rsp_stats_ff;

endmodule

[rtl/wds_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/wds_checker.sv]
// Port-level checks for windowed_duration_statistics, attached by bind.
// Depends on wds_pkg and the top-level port list.
module wds_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_operation,
   input logic [31:0]        req_timestamp_ms,
   input logic               req_enable_request,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_interval_ms,
   input logic signed [31:0] rsp_window_min,
   input logic signed [31:0] rsp_window_max,
   input logic signed [39:0] rsp_window_sum,
   input logic               rsp_stats_valid
);

   logic acc;
   assign acc = start && !busy;

   // start and set-enable always answer on the next cycle
   a_quick_word: assert property (@(posedge clock) disable iff (reset)
      acc && (req_operation == wds_pkg::OP_START || req_operation == wds_pkg::OP_ENABLE)
      |=> rsp_strobe && !rsp_stats_valid && rsp_interval_ms == 0)
      else $error("start/enable word missing or not zero");

   // finish always goes through the scan
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      acc && req_operation == wds_pkg::OP_FINISH |=> busy && !rsp_strobe)
      else $error("finish did not hold off requests");

   // statistics word comes only at the end of a scan
   a_stats_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_stats_valid |-> $past(busy) && rsp_interval_ms == 0)
      else $error("statistics word outside a scan");

   a_nonstats_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_stats_valid
      |-> rsp_window_min == 0 && rsp_window_max == 0 && rsp_window_sum == 0)
      else $error("window fields set on a non-finish word");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_stats_valid |-> rsp_window_min <= rsp_window_max)
      else $error("window min above max");

endmodule

bind windowed_duration_statistics wds_checker u_wds_checker (.*);

[sim/tb.sv]
// Self-checking bench for windowed_duration_statistics: directed and random words
// driven through the start/busy port, results checked against an in-bench predictor.
// Depends on wds_pkg and the block's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 4 * wds_pkg::SAMPLES;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      wds_pkg::op_type op;
      logic [31:0]     ts;
      logic            en;
   } section_cmd_type;

   typedef struct {
      logic signed [31:0] interval;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [39:0] sum;
      logic               stats;
   } window_stats_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_operation = 2'd0;
   logic [31:0]        req_timestamp_ms = 32'd0;
   logic               req_enable_request = 1'b0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_interval_ms;
   logic signed [31:0] rsp_window_min;
   logic signed [31:0] rsp_window_max;
   logic signed [39:0] rsp_window_sum;
   logic               rsp_stats_valid;

   windowed_duration_statistics dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_enable_request (req_enable_request),
      .rsp_strobe         (rsp_strobe),
      .rsp_interval_ms    (rsp_interval_ms),
      .rsp_window_min     (rsp_window_min),
      .rsp_window_max     (rsp_window_max),
      .rsp_window_sum     (rsp_window_sum),
      .rsp_stats_valid    (rsp_stats_valid)
   );

   // predictor state
   logic [31:0]                slot_dur [wds_pkg::SAMPLES];
   logic [31:0]                slot_begin [wds_pkg::SAMPLES];
   logic [wds_pkg::SLOT_W-1:0] slot_ptr;
   logic                       prof_active;
   logic                       enable_pending;

   section_cmd_type  pending_words[$];
   window_stats_type expected_words[$];
   section_cmd_type  next_word;
   window_stats_type seen_word;
   window_stats_type want_word;

   int accepted_count = 0;
   int windows_closed = 0;
   int active_stops   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int random_count   = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic window_stats_type step_window_stats(wds_pkg::op_type op,
                                                          logic [31:0] ts, logic en);
      window_stats_type r;
      logic [31:0]      dt;
      longint           acc;
      int               d;
      int               lo;
      int               hi;
      r = '{default: '0};
      case (op)
         wds_pkg::OP_START: begin
            if (prof_active) slot_begin[slot_ptr] = ts;
         end
         wds_pkg::OP_STOP: begin
            if (prof_active) begin
               dt = ts - slot_begin[slot_ptr];
               slot_dur[slot_ptr] = slot_dur[slot_ptr] + dt;
               r.interval = dt;
               active_stops++;
            end
         end
         wds_pkg::OP_FINISH: begin
            slot_ptr = (slot_ptr == wds_pkg::SLOT_LAST) ? '0 : slot_ptr + 1'b1;
            // scan sees the new slot before it is cleared
            lo = slot_dur[0];
            hi = lo;
            acc = lo;
            for (int k = 1; k < wds_pkg::SAMPLES; k++) begin
               d = slot_dur[k];
               acc += d;
               if (d < lo) lo = d;
               if (d > hi) hi = d;
            end
            slot_dur[slot_ptr] = '0;
            prof_active = enable_pending;
            r.lo = lo;
            r.hi = hi;
            r.sum = acc[39:0];
            r.stats = 1'b1;
            windows_closed++;
         end
         wds_pkg::OP_ENABLE: begin
            enable_pending = en;
         end
      endcase
      return r;
   endfunction

   task automatic add_word(wds_pkg::op_type op, logic [31:0] ts, logic en);
      section_cmd_type w;
      w.op = op;
      w.ts = ts;
      w.en = en;
      pending_words.push_back(w);
      random_count++;
   endtask

   task automatic add_timed_pair(logic [31:0] t0, logic [31:0] span);
      add_word(wds_pkg::OP_START, t0, 1'($urandom));
      add_word(wds_pkg::OP_STOP, t0 + span, 1'($urandom));
   endtask

   task automatic fill_directed();
      add_word(wds_pkg::OP_STOP, 32'hFFFF_FFFF, 1'b1);     // inactive: zero result
      add_word(wds_pkg::OP_START, 32'hFFFF_FFFF, 1'b1);
      add_word(wds_pkg::OP_FINISH, 32'h0, 1'b0);
      add_word(wds_pkg::OP_ENABLE, 32'hFFFF_FFFF, 1'b1);
      add_word(wds_pkg::OP_STOP, 32'd5, 1'b0);              // enable not in effect yet
      add_word(wds_pkg::OP_FINISH, 32'h0, 1'b1);
      add_word(wds_pkg::OP_STOP, 32'd100, 1'b0);            // stop without a start
      add_timed_pair(32'hFFFF_FFF0, 32'h20);                 // timestamp wraps
      add_word(wds_pkg::OP_START, 32'd1000, 1'b0);
      add_word(wds_pkg::OP_STOP, 32'd0, 1'b0);              // negative interval
      add_timed_pair(32'h0, 32'h7FFF_FFFF);
      add_word(wds_pkg::OP_FINISH, 32'hFFFF_FFFF, 1'b0);
      add_timed_pair(32'h0, 32'h7FFF_FFFF);
      add_timed_pair(32'h8000_0000, 32'h7FFF_FFFF);          // slot duration wraps
      add_word(wds_pkg::OP_ENABLE, 32'h0, 1'b0);
      add_timed_pair(32'h0, 32'h8000_0000);                  // most negative interval
      add_word(wds_pkg::OP_FINISH, 32'h0, 1'b0);
      add_word(wds_pkg::OP_STOP, 32'd12345, 1'b1);
      add_word(wds_pkg::OP_ENABLE, 32'h0, 1'b1);
      add_word(wds_pkg::OP_FINISH, 32'h0, 1'b0);
   endtask

   task automatic fill_random();
      int          pick;
      int          pairs;
      logic [31:0] span;
      random_count = 0;
      while (random_count < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            pairs = $urandom_range(4);
            repeat (pairs) begin
               span = ($urandom_range(99) < 12) ? $urandom : $urandom_range(20000);
               add_timed_pair($urandom, span);
            end
            add_word(wds_pkg::OP_FINISH, $urandom, 1'($urandom));
         end else if (pick < 85) begin
            add_word(wds_pkg::OP_ENABLE, $urandom, 1'($urandom_range(99) < 75));
         end else begin
            add_word(wds_pkg::op_type'($urandom_range(3)), $urandom, 1'($urandom));
         end
      end
   endtask

   // driver: next word goes out once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_words.push_back(step_window_stats(wds_pkg::op_type'(req_operation),
                                                       req_timestamp_ms,
                                                       req_enable_request));
            accepted_count++;
         end
         if (!start || !busy) begin
            if (pending_words.size() > 0 &&
                ((accepted_count >= 350 && accepted_count < 520) ||
                 $urandom_range(99) >= 35)) begin
               next_word = pending_words.pop_front();
               start <= 1'b1;
               req_operation <= next_word.op;
               req_timestamp_ms <= next_word.ts;
               req_enable_request <= next_word.en;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each strobed word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_word.interval = rsp_interval_ms;
         seen_word.lo = rsp_window_min;
         seen_word.hi = rsp_window_max;
         seen_word.sum = rsp_window_sum;
         seen_word.stats = rsp_stats_valid;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected word: interval=%0d min=%0d max=%0d sum=%0d v=%b",
                        $realtime, seen_word.interval, seen_word.lo, seen_word.hi,
                        seen_word.sum, seen_word.stats);
         end else begin
            want_word = expected_words.pop_front();
            if (seen_word.interval !== want_word.interval || seen_word.lo !== want_word.lo ||
                seen_word.hi !== want_word.hi || seen_word.sum !== want_word.sum ||
                seen_word.stats !== want_word.stats) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("%0t: mismatch exp interval=%0d min=%0d max=%0d sum=%0d v=%b",
                           $realtime, want_word.interval, want_word.lo, want_word.hi,
                           want_word.sum, want_word.stats);
                  $display("            got interval=%0d min=%0d max=%0d sum=%0d v=%b",
                           seen_word.interval, seen_word.lo, seen_word.hi,
                           seen_word.sum, seen_word.stats);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_words.size());
         $display("[windowed_duration_statistics] ERROR");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < wds_pkg::SAMPLES; k++) begin
         slot_dur[k] = '0;
         slot_begin[k] = '0;
      end
      slot_ptr = '0;
      prof_active = 1'b0;
      enable_pending = 1'b0;

      fill_directed();
      fill_random();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || start) @(posedge clock);
      while (expected_words.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_words.size() > 0) mismatch_count++;
      $display("ran %0d words: %0d windows closed, %0d timed stops while active",
               accepted_count, windows_closed, active_stops);
      $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("[windowed_duration_statistics] OK");
      end else begin
         $display("[windowed_duration_statistics] ERROR");
      end
      $finish;
   end

endmodule
